FILE: hdl/lam_pkg.sv
// ----------------------------------------------------------------------------
// lam_pkg
// shared widths and output saturation for the look-at matrix pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lam_pkg;

  localparam int COORD_W = 32;
  localparam int OUT_W   = 18;

  localparam logic signed [63:0] OUT_MAX = 64'sd131071;
  localparam logic signed [63:0] OUT_MIN = -64'sd131072;

  // clamp a wide signed value into an output entry
  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [63:0] x);
    logic signed [OUT_W-1:0] r;
    if (x > OUT_MAX) begin
      r = OUT_W'(OUT_MAX);
    end else if (x < OUT_MIN) begin
      r = OUT_W'(OUT_MIN);
    end else begin
      r = OUT_W'(x);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/lam_norm.sv
// ----------------------------------------------------------------------------
// lam_norm
// pipelined 3-vector normalize: scale, sum of squares, root, per-bit divide
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lam_norm #(
  parameter int IN_W   = 33,
  parameter int FB     = 16,
  parameter int SIDE_W = 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_v,
  input  logic signed [IN_W-1:0]   in_vec [3],
  input  logic [SIDE_W-1:0]        in_side,
  output logic                     out_v,
  output logic signed [FB+1:0]     out_vec [3],
  output logic [SIDE_W-1:0]        out_side
);

  localparam int A_W      = 30;
  localparam int S_W      = 62;
  localparam int R_W      = 31;
  localparam int REM_W    = 35;
  localparam int SQ_N     = 31;
  localparam int TOP_BIT  = 29;
  localparam int MSB_W    = $clog2(IN_W);
  localparam int G        = (IN_W + 7) / 8;
  localparam int NW       = A_W + 1 + FB;
  localparam int QW       = FB + 1;
  localparam int OW       = FB + 2;

  // stage 1: magnitudes and max
  logic              p1_v;
  logic [IN_W-1:0]   p1_a [3];
  logic              p1_neg [3];
  logic [IN_W-1:0]   p1_m;
  logic [SIDE_W-1:0] p1_side;
  logic [IN_W-1:0]   abs_c [3];
  logic [IN_W-1:0]   max01;

  // stage 2: per-byte leading one
  logic              p2_v;
  logic [IN_W-1:0]   p2_a [3];
  logic              p2_neg [3];
  logic              p2_zero;
  logic              p2_nz [G];
  logic [2:0]        p2_pos [G];
  logic [SIDE_W-1:0] p2_side;
  logic [G*8-1:0]    m_pad;
  logic              nz_c [G];
  logic [2:0]        pos_c [G];

  // stage 3: shift amount
  logic              p3_v;
  logic [IN_W-1:0]   p3_a [3];
  logic              p3_neg [3];
  logic              p3_zero;
  logic              p3_right;
  logic [MSB_W-1:0]  p3_amt;
  logic [SIDE_W-1:0] p3_side;
  logic [MSB_W-1:0]  msb_c;

  // stage 4: scaled magnitudes
  logic              p4_v;
  logic [A_W-1:0]    p4_a [3];
  logic              p4_neg [3];
  logic              p4_zero;
  logic [SIDE_W-1:0] p4_side;
  logic [IN_W-1:0]   sh_c [3];

  // stage 5: squares
  logic              p5_v;
  logic [2*A_W-1:0]  p5_sq [3];
  logic [A_W-1:0]    p5_a [3];
  logic              p5_neg [3];
  logic              p5_zero;
  logic [SIDE_W-1:0] p5_side;

  // root stages, index 0 holds the sum of squares
  logic              sq_v    [SQ_N+1];
  logic [S_W-1:0]    sq_s    [SQ_N+1];
  logic [REM_W-1:0]  sq_rem  [SQ_N+1];
  logic [R_W-1:0]    sq_root [SQ_N+1];
  logic [A_W-1:0]    sq_a    [SQ_N+1][3];
  logic              sq_neg  [SQ_N+1][3];
  logic              sq_zero [SQ_N+1];
  logic [SIDE_W-1:0] sq_side [SQ_N+1];
  logic [REM_W-1:0]  rem_nx  [SQ_N];
  logic [R_W-1:0]    root_nx [SQ_N];

  // divide stages, index 0 holds the rounded numerators
  logic              dv_v    [QW+1];
  logic [NW-1:0]     dv_n    [QW+1][3];
  logic [QW-1:0]     dv_q    [QW+1][3];
  logic [R_W-1:0]    dv_r    [QW+1];
  logic              dv_neg  [QW+1][3];
  logic              dv_zero [QW+1];
  logic [SIDE_W-1:0] dv_side [QW+1];
  logic [NW-1:0]     n_nx    [QW][3];
  logic [QW-1:0]     q_nx    [QW][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_c[i] = in_vec[i][IN_W-1] ? IN_W'(~in_vec[i] + 1'b1) : IN_W'(in_vec[i]);
    end
    max01 = (abs_c[0] > abs_c[1]) ? abs_c[0] : abs_c[1];
  end

  assign m_pad = (G*8)'(p1_m);

  always_comb begin
    for (int g = 0; g < G; g++) begin
      nz_c[g]  = |m_pad[g*8 +: 8];
      pos_c[g] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (m_pad[g*8 + b]) begin
          pos_c[g] = 3'(b);
        end
      end
    end
  end

  always_comb begin
    msb_c = '0;
    for (int g = 0; g < G; g++) begin
      if (p2_nz[g]) begin
        msb_c = MSB_W'(g * 8) + MSB_W'(p2_pos[g]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh_c[i] = p3_right ? (p3_a[i] >> p3_amt) : (p3_a[i] << p3_amt);
    end
  end

  // one result bit of the square root per stage
  always_comb begin
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    for (int k = 0; k < SQ_N; k++) begin
      rem_sh     = {sq_rem[k][REM_W-3:0], sq_s[k][S_W-1:S_W-2]};
      trial      = REM_W'({sq_root[k], 2'b01});
      rem_nx[k]  = (rem_sh >= trial) ? (rem_sh - trial) : rem_sh;
      root_nx[k] = {sq_root[k][R_W-2:0], rem_sh >= trial};
    end
  end

  // one quotient bit per stage, most significant first
  always_comb begin
    logic [NW-1:0] dvs;
    for (int j = 0; j < QW; j++) begin
      dvs = NW'(dv_r[j]) << (QW - 1 - j);
      for (int i = 0; i < 3; i++) begin
        n_nx[j][i] = (dv_n[j][i] >= dvs) ? (dv_n[j][i] - dvs) : dv_n[j][i];
        q_nx[j][i] = dv_q[j][i] | (QW'(dv_n[j][i] >= dvs) << (QW - 1 - j));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v  <= 1'b0;
      p2_v  <= 1'b0;
      p3_v  <= 1'b0;
      p4_v  <= 1'b0;
      p5_v  <= 1'b0;
      for (int k = 0; k <= SQ_N; k++) sq_v[k] <= 1'b0;
      for (int j = 0; j <= QW; j++) dv_v[j] <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      p1_v    <= in_v;
      p2_v    <= p1_v;
      p3_v    <= p2_v;
      p4_v    <= p3_v;
      p5_v    <= p4_v;
      sq_v[0] <= p5_v;
      for (int k = 0; k < SQ_N; k++) sq_v[k+1] <= sq_v[k];
      dv_v[0] <= sq_v[SQ_N];
      for (int j = 0; j < QW; j++) dv_v[j+1] <= dv_v[j];
      out_v   <= dv_v[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p1_a[i]   <= abs_c[i];
        p1_neg[i] <= in_vec[i][IN_W-1];
      end
      p1_m    <= (max01 > abs_c[2]) ? max01 : abs_c[2];
      p1_side <= in_side;

      p2_a    <= p1_a;
      p2_neg  <= p1_neg;
      p2_zero <= (p1_m == '0);
      p2_nz   <= nz_c;
      p2_pos  <= pos_c;
      p2_side <= p1_side;

      p3_a     <= p2_a;
      p3_neg   <= p2_neg;
      p3_zero  <= p2_zero;
      p3_right <= (msb_c > MSB_W'(TOP_BIT));
      p3_amt   <= (msb_c > MSB_W'(TOP_BIT)) ? (msb_c - MSB_W'(TOP_BIT))
                                             : (MSB_W'(TOP_BIT) - msb_c);
      p3_side  <= p2_side;

      for (int i = 0; i < 3; i++) p4_a[i] <= sh_c[i][A_W-1:0];
      p4_neg  <= p3_neg;
      p4_zero <= p3_zero;
      p4_side <= p3_side;

      for (int i = 0; i < 3; i++) p5_sq[i] <= p4_a[i] * p4_a[i];
      p5_a    <= p4_a;
      p5_neg  <= p4_neg;
      p5_zero <= p4_zero;
      p5_side <= p4_side;

      sq_s[0]    <= S_W'(p5_sq[0]) + S_W'(p5_sq[1]) + S_W'(p5_sq[2]);
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_a[0]    <= p5_a;
      sq_neg[0]  <= p5_neg;
      sq_zero[0] <= p5_zero;
      sq_side[0] <= p5_side;
      for (int k = 0; k < SQ_N; k++) begin
        sq_s[k+1]    <= sq_s[k] << 2;
        sq_rem[k+1]  <= rem_nx[k];
        sq_root[k+1] <= root_nx[k];
        sq_a[k+1]    <= sq_a[k];
        sq_neg[k+1]  <= sq_neg[k];
        sq_zero[k+1] <= sq_zero[k];
        sq_side[k+1] <= sq_side[k];
      end

      // numerator rounds the quotient to nearest
      for (int i = 0; i < 3; i++) begin
        dv_n[0][i] <= (NW'(sq_a[SQ_N][i]) << FB) + NW'(sq_root[SQ_N] >> 1);
        dv_q[0][i] <= '0;
      end
      dv_r[0]    <= sq_root[SQ_N];
      dv_neg[0]  <= sq_neg[SQ_N];
      dv_zero[0] <= sq_zero[SQ_N];
      dv_side[0] <= sq_side[SQ_N];
      for (int j = 0; j < QW; j++) begin
        dv_n[j+1]    <= n_nx[j];
        dv_q[j+1]    <= q_nx[j];
        dv_r[j+1]    <= dv_r[j];
        dv_neg[j+1]  <= dv_neg[j];
        dv_zero[j+1] <= dv_zero[j];
        dv_side[j+1] <= dv_side[j];
      end

      for (int i = 0; i < 3; i++) begin
        if (dv_zero[QW]) begin
          out_vec[i] <= '0;
        end else if (dv_neg[QW][i]) begin
          out_vec[i] <= -$signed(OW'(dv_q[QW][i]));
        end else begin
          out_vec[i] <= $signed(OW'(dv_q[QW][i]));
        end
      end
      out_side <= dv_side[QW];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/lam_cross.sv
// ----------------------------------------------------------------------------
// lam_cross
// two-stage exact cross product a x b
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lam_cross #(
  parameter int AW     = 18,
  parameter int BW     = 32,
  parameter int SIDE_W = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_v,
  input  logic signed [AW-1:0]      a [3],
  input  logic signed [BW-1:0]      b [3],
  input  logic [SIDE_W-1:0]         in_side,
  output logic                      out_v,
  output logic signed [AW+BW:0]     c [3],
  output logic [SIDE_W-1:0]         out_side
);

  localparam int PW = AW + BW;
  localparam int CW = PW + 1;

  logic                 pr_v;
  logic signed [PW-1:0] pr [6];
  logic [SIDE_W-1:0]    pr_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      pr_v  <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      pr_v  <= in_v;
      out_v <= pr_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr[0]   <= a[1] * b[2];
      pr[1]   <= a[2] * b[1];
      pr[2]   <= a[2] * b[0];
      pr[3]   <= a[0] * b[2];
      pr[4]   <= a[0] * b[1];
      pr[5]   <= a[1] * b[0];
      pr_side <= in_side;

      c[0]     <= CW'(pr[0]) - CW'(pr[1]);
      c[1]     <= CW'(pr[2]) - CW'(pr[3]);
      c[2]     <= CW'(pr[4]) - CW'(pr[5]);
      out_side <= pr_side;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/lam_ofifo.sv
// ----------------------------------------------------------------------------
// lam_ofifo
// two-entry output queue that decouples the pipeline from the receiver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lam_ofifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  output logic         valid,
  output logic [W-1:0] dout,
  input  logic         stall
);

  localparam logic [1:0] DEPTH = 2'd2;

  logic [W-1:0] mem [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   count;
  logic         pop;

  assign pop   = valid & ~stall;
  assign full  = (count == DEPTH);
  assign valid = (count != 2'd0);
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= din;
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> count != DEPTH)
    else $error("word pushed into full output queue");
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (full && !pop) |=> full)
    else $error("output queue left full without a pop");
  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> count == $past(count) - 2'd1)
    else $error("pop did not lower the fill level");
`endif

endmodule

`default_nettype wire

FILE: hdl/look_at_camera_matrix.sv
// ----------------------------------------------------------------------------
// look_at_camera_matrix
// look-at camera rotation columns and eye translation in signed fixed point
// ----------------------------------------------------------------------------
// input channel: in_valid / in_stall carries one word of eye, target and up
// hint; a word is taken at a clock edge with in_valid high and in_stall low.
// output channel: out_valid / out_stall carries side, true up, back and the
// eye point as translation; a word leaves when out_valid is high and
// out_stall is low.
// throughput: one word per cycle while in_stall is low. each word passes
// through the two normalize units, each a 31-stage square root and a
// FRAC_BITS+1 stage divider, plus the cross product, rounding and output
// queue stages.
// a two-entry output queue sits behind the pipeline; the whole pipeline
// advances only while that queue has room, so when the receiver stalls,
// words keep entering until the queue fills, then in_stall rises and every
// stage holds its word until a slot frees.
// reset (rst, synchronous) empties all stages and the queue; nothing is
// kept between words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module look_at_camera_matrix #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [lam_pkg::COORD_W-1:0] eye_x,
  input  logic signed [lam_pkg::COORD_W-1:0] eye_y,
  input  logic signed [lam_pkg::COORD_W-1:0] eye_z,
  input  logic signed [lam_pkg::COORD_W-1:0] target_x,
  input  logic signed [lam_pkg::COORD_W-1:0] target_y,
  input  logic signed [lam_pkg::COORD_W-1:0] target_z,
  input  logic signed [lam_pkg::COORD_W-1:0] upward_x,
  input  logic signed [lam_pkg::COORD_W-1:0] upward_y,
  input  logic signed [lam_pkg::COORD_W-1:0] upward_z,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [lam_pkg::OUT_W-1:0]   side_x,
  output logic signed [lam_pkg::OUT_W-1:0]   side_y,
  output logic signed [lam_pkg::OUT_W-1:0]   side_z,
  output logic signed [lam_pkg::OUT_W-1:0]   true_up_x,
  output logic signed [lam_pkg::OUT_W-1:0]   true_up_y,
  output logic signed [lam_pkg::OUT_W-1:0]   true_up_z,
  output logic signed [lam_pkg::OUT_W-1:0]   back_x,
  output logic signed [lam_pkg::OUT_W-1:0]   back_y,
  output logic signed [lam_pkg::OUT_W-1:0]   back_z,
  output logic signed [lam_pkg::COORD_W-1:0] shift_x,
  output logic signed [lam_pkg::COORD_W-1:0] shift_y,
  output logic signed [lam_pkg::COORD_W-1:0] shift_z
);

  import lam_pkg::*;

  localparam int FB     = FRAC_BITS;
  localparam int DW     = COORD_W + 1;
  localparam int OW     = FB + 2;
  localparam int CW     = OW + COORD_W + 1;
  localparam int UW     = 2 * OW + 1;
  localparam int EYE_W  = 3 * COORD_W;
  localparam int SIDE1  = 2 * EYE_W;
  localparam int SIDE2  = EYE_W + 3 * OW;
  localparam int SIDE3  = EYE_W + 6 * OW;
  localparam int WORD_W = 9 * OUT_W + EYE_W;

  localparam logic signed [UW:0] HALF = (UW+1)'(1) << (FB - 1);

  logic en;
  logic full;

  // entry stage
  logic                    t0_v;
  logic signed [DW-1:0]    t0_d [3];
  logic [SIDE1-1:0]        t0_side;

  // first normalize
  logic                    n1_v;
  logic signed [OW-1:0]    f_vec [3];
  logic [SIDE1-1:0]        n1_side;
  logic signed [COORD_W-1:0] up_vec [3];

  // forward x up
  logic                    c1_v;
  logic signed [CW-1:0]    c_vec [3];
  logic [SIDE2-1:0]        c1_side;

  // second normalize
  logic                    n2_v;
  logic signed [OW-1:0]    s_vec [3];
  logic [SIDE2-1:0]        n2_side;
  logic signed [OW-1:0]    f2_vec [3];

  // side x forward
  logic                    c2_v;
  logic signed [UW-1:0]    u_raw [3];
  logic [SIDE3-1:0]        c2_side;
  logic signed [OW-1:0]    s3_vec [3];
  logic signed [OW-1:0]    f3_vec [3];

  // final rounding and clamp
  logic                    fin_v;
  logic [WORD_W-1:0]       fin_word;
  logic [WORD_W-1:0]       word_c;
  logic signed [UW:0]      rnd_c [3];
  logic signed [OUT_W-1:0] side_c [3];
  logic signed [OUT_W-1:0] up_c [3];
  logic signed [OUT_W-1:0] back_c [3];
  logic [WORD_W-1:0]       q_word;

  assign en       = ~full;
  assign in_stall = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      t0_v  <= 1'b0;
      fin_v <= 1'b0;
    end else if (en) begin
      t0_v  <= in_valid;
      fin_v <= c2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0_d[0] <= DW'(target_x) - DW'(eye_x);
      t0_d[1] <= DW'(target_y) - DW'(eye_y);
      t0_d[2] <= DW'(target_z) - DW'(eye_z);
      t0_side <= {eye_x, eye_y, eye_z, upward_x, upward_y, upward_z};
      fin_word <= word_c;
    end
  end

  lam_norm #(.IN_W(DW), .FB(FB), .SIDE_W(SIDE1)) u_norm_fwd (
    .clk(clk), .rst(rst), .en(en),
    .in_v(t0_v), .in_vec(t0_d), .in_side(t0_side),
    .out_v(n1_v), .out_vec(f_vec), .out_side(n1_side)
  );

  assign up_vec[0] = n1_side[3*COORD_W-1:2*COORD_W];
  assign up_vec[1] = n1_side[2*COORD_W-1:COORD_W];
  assign up_vec[2] = n1_side[COORD_W-1:0];

  lam_cross #(.AW(OW), .BW(COORD_W), .SIDE_W(SIDE2)) u_cross_side (
    .clk(clk), .rst(rst), .en(en),
    .in_v(n1_v), .a(f_vec), .b(up_vec),
    .in_side({n1_side[SIDE1-1:EYE_W], f_vec[0], f_vec[1], f_vec[2]}),
    .out_v(c1_v), .c(c_vec), .out_side(c1_side)
  );

  lam_norm #(.IN_W(CW), .FB(FB), .SIDE_W(SIDE2)) u_norm_side (
    .clk(clk), .rst(rst), .en(en),
    .in_v(c1_v), .in_vec(c_vec), .in_side(c1_side),
    .out_v(n2_v), .out_vec(s_vec), .out_side(n2_side)
  );

  assign f2_vec[0] = n2_side[3*OW-1:2*OW];
  assign f2_vec[1] = n2_side[2*OW-1:OW];
  assign f2_vec[2] = n2_side[OW-1:0];

  lam_cross #(.AW(OW), .BW(OW), .SIDE_W(SIDE3)) u_cross_up (
    .clk(clk), .rst(rst), .en(en),
    .in_v(n2_v), .a(s_vec), .b(f2_vec),
    .in_side({n2_side, s_vec[0], s_vec[1], s_vec[2]}),
    .out_v(c2_v), .c(u_raw), .out_side(c2_side)
  );

  // side word layout: eye, forward, side
  assign s3_vec[0] = c2_side[3*OW-1:2*OW];
  assign s3_vec[1] = c2_side[2*OW-1:OW];
  assign s3_vec[2] = c2_side[OW-1:0];
  assign f3_vec[0] = c2_side[6*OW-1:5*OW];
  assign f3_vec[1] = c2_side[5*OW-1:4*OW];
  assign f3_vec[2] = c2_side[4*OW-1:3*OW];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // round half toward plus infinity, then drop the fraction
      rnd_c[i]  = ((UW+1)'(u_raw[i]) + HALF) >>> FB;
      side_c[i] = sat_out(64'(s3_vec[i]));
      up_c[i]   = sat_out(64'(rnd_c[i]));
      back_c[i] = sat_out(-(64'(f3_vec[i])));
    end
    word_c = {side_c[0], side_c[1], side_c[2], up_c[0], up_c[1], up_c[2],
              back_c[0], back_c[1], back_c[2], c2_side[SIDE3-1:SIDE3-EYE_W]};
  end

  lam_ofifo #(.W(WORD_W)) u_ofifo (
    .clk(clk), .rst(rst),
    .push(en & fin_v), .din(fin_word), .full(full),
    .valid(out_valid), .dout(q_word), .stall(out_stall)
  );

  assign side_x    = q_word[WORD_W-1          -: OUT_W];
  assign side_y    = q_word[WORD_W-1-OUT_W    -: OUT_W];
  assign side_z    = q_word[WORD_W-1-2*OUT_W  -: OUT_W];
  assign true_up_x = q_word[WORD_W-1-3*OUT_W  -: OUT_W];
  assign true_up_y = q_word[WORD_W-1-4*OUT_W  -: OUT_W];
  assign true_up_z = q_word[WORD_W-1-5*OUT_W  -: OUT_W];
  assign back_x    = q_word[WORD_W-1-6*OUT_W  -: OUT_W];
  assign back_y    = q_word[WORD_W-1-7*OUT_W  -: OUT_W];
  assign back_z    = q_word[WORD_W-1-8*OUT_W  -: OUT_W];
  assign shift_x   = q_word[3*COORD_W-1:2*COORD_W];
  assign shift_y   = q_word[2*COORD_W-1:COORD_W];
  assign shift_z   = q_word[COORD_W-1:0];

endmodule

`default_nettype wire

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// look-at matrix regression: directed corner vectors then random camera sets,
// each result checked field by field against an in-bench fixed-point model
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  import lam_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = 2 * FRAC + 86;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [OUT_W-1:0] entry_t;

  typedef struct packed {
    entry_t side_x, side_y, side_z;
    entry_t up_x, up_y, up_z;
    entry_t back_x, back_y, back_z;
    coord_t sh_x, sh_y, sh_z;
  } matrix_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  coord_t eye_x = 0, eye_y = 0, eye_z = 0;
  coord_t target_x = 0, target_y = 0, target_z = 0;
  coord_t upward_x = 0, upward_y = 0, upward_z = 0;
  logic out_valid;
  logic out_stall = 0;
  entry_t side_x, side_y, side_z, true_up_x, true_up_y, true_up_z;
  entry_t back_x, back_y, back_z;
  coord_t shift_x, shift_y, shift_z;

  matrix_t expected_matrices[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit hold_receiver = 0;
  bit random_stall = 1;

  always #6 clk = ~clk;

  look_at_camera_matrix #(.FRAC_BITS(FRAC)) DUT (.*);

  // floor square root, bit by bit
  function automatic longint unsigned floor_sqrt(input longint unsigned s);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic void unit_vector(input longint v[3], output longint o[3]);
    longint unsigned a[3], m, s, r, q;
    bit neg[3];
    m = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      a[i] = neg[i] ? -v[i] : v[i];
      if (a[i] > m) m = a[i];
    end
    if (m == 0) begin
      o = '{0, 0, 0};
      return;
    end
    while (m >= (64'd1 << 30)) begin
      m >>= 1;
      for (int i = 0; i < 3; i++) a[i] >>= 1;
    end
    while (m < (64'd1 << 29)) begin
      m <<= 1;
      for (int i = 0; i < 3; i++) a[i] <<= 1;
    end
    s = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    r = floor_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = ((a[i] << FRAC) + (r >> 1)) / r;
      o[i] = neg[i] ? -longint'(q) : longint'(q);
    end
  endfunction

  // nearest after dropping the fraction, halves up
  function automatic longint round_frac(input longint x);
    return (x + (longint'(1) << (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic entry_t clamp(input longint x);
    if (x > 131071) return 18'sd131071;
    if (x < -131072) return -18'sd131072;
    return entry_t'(x);
  endfunction

  function automatic matrix_t camera_matrix(input coord_t e[3], input coord_t t[3],
                                            input coord_t u[3]);
    longint d[3], f[3], c[3], s[3], w[3];
    matrix_t m;
    for (int i = 0; i < 3; i++) d[i] = longint'(t[i]) - longint'(e[i]);
    unit_vector(d, f);
    c[0] = f[1] * u[2] - f[2] * u[1];
    c[1] = f[2] * u[0] - f[0] * u[2];
    c[2] = f[0] * u[1] - f[1] * u[0];
    unit_vector(c, s);
    w[0] = round_frac(s[1] * f[2] - s[2] * f[1]);
    w[1] = round_frac(s[2] * f[0] - s[0] * f[2]);
    w[2] = round_frac(s[0] * f[1] - s[1] * f[0]);
    m.side_x = clamp(s[0]); m.side_y = clamp(s[1]); m.side_z = clamp(s[2]);
    m.up_x = clamp(w[0]); m.up_y = clamp(w[1]); m.up_z = clamp(w[2]);
    m.back_x = clamp(-f[0]); m.back_y = clamp(-f[1]); m.back_z = clamp(-f[2]);
    m.sh_x = e[0]; m.sh_y = e[1]; m.sh_z = e[2];
    return m;
  endfunction

  function automatic int short_gap();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  // one word onto the input channel; valid stays up between back-to-back words
  task automatic send_camera(input coord_t e[3], input coord_t t[3], input coord_t u[3],
                             input bit gaps);
    int gap;
    gap = gaps ? short_gap() : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    eye_x <= e[0]; eye_y <= e[1]; eye_z <= e[2];
    target_x <= t[0]; target_y <= t[1]; target_z <= t[2];
    upward_x <= u[0]; upward_y <= u[1]; upward_z <= u[2];
    expected_matrices.push_back(camera_matrix(e, t, u));
    do @(posedge clk); while (in_stall);
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'($urandom);
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      2: return coord_t'($urandom_range(0, 8)) - 4;
      default: return coord_t'(int'($urandom_range(0, 2097152)) - 1048576);
    endcase
  endfunction

  task automatic random_camera(input bit gaps);
    coord_t e[3], t[3], u[3];
    for (int i = 0; i < 3; i++) begin
      e[i] = rand_coord(); t[i] = rand_coord(); u[i] = rand_coord();
    end
    if ($urandom_range(0, 15) == 0) t = e;
    if ($urandom_range(0, 15) == 0) u = '{0, 0, 0};
    if ($urandom_range(0, 15) == 0) for (int i = 0; i < 3; i++) u[i] = t[i] - e[i];
    send_camera(e, t, u, gaps);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (expected_matrices.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    coord_t one = 32'sh10000;
    coord_t mx = 32'sh7fffffff, mn = 32'sh80000000;
    send_camera('{0, 0, 0}, '{0, 0, -one}, '{0, one, 0}, 0);
    send_camera('{0, 0, 0}, '{0, 0, 0}, '{0, one, 0}, 0);       // eye on target
    send_camera('{0, 0, 0}, '{one, 0, 0}, '{0, 0, 0}, 0);       // zero up hint
    send_camera('{0, 0, 0}, '{0, one, 0}, '{0, -one, 0}, 0);    // up parallel to view
    send_camera('{mn, mn, mn}, '{mx, mx, mx}, '{mx, mn, 0}, 0);
    send_camera('{mx, mx, mx}, '{mn, mn, mn}, '{mn, mx, mn}, 0);
    send_camera('{mx, mn, mx}, '{mn, mx, mn}, '{mx, mx, mx}, 0);
    send_camera('{1, -1, 0}, '{-1, 1, 1}, '{1, 1, -1}, 0);
    send_camera('{-one, one, 3}, '{one, -one, 5}, '{mn, mn, mn}, 0);
    send_camera('{32'sh55555555, 32'shaaaaaaaa, 0}, '{0, 1, 2}, '{-1, -1, -1}, 0);
    wait_drained();
  endtask

  task automatic test_random();
    for (int n = 0; n < 2000; n++) random_camera(1);
    wait_drained();
  endtask

  task automatic test_backpressure();
    random_stall = 0;
    hold_receiver = 1;
    for (int n = 0; n < 200; n++) random_camera(0);
    wait_drained();
    random_stall = 1;
  endtask

  // long receiver hold counted in its own process
  always @(posedge clk) begin
    if (hold_receiver) begin
      repeat (400) @(posedge clk);
      hold_receiver <= 0;
    end
  end

  // receiver stalls: mostly single cycles, now and then a long run
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
      stall_left <= 0;
    end else if (hold_receiver) begin
      out_stall <= 1;
    end else if (!random_stall) begin
      out_stall <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) == 0) begin
      out_stall <= 1;
      stall_left <= $urandom_range(10, 40);
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall <= 1;
    end else begin
      out_stall <= 0;
    end
  end

  // checker for each accepted result word
  always @(posedge clk) begin
    matrix_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{side_x, side_y, side_z, true_up_x, true_up_y, true_up_z,
              back_x, back_y, back_z, shift_x, shift_y, shift_z};
      if (expected_matrices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
      end else begin
        want = expected_matrices.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch\n  exp side %0d %0d %0d up %0d %0d %0d",
                     want.side_x, want.side_y, want.side_z,
                     want.up_x, want.up_y, want.up_z);
            $display("  exp back %0d %0d %0d sh %0d %0d %0d",
                     want.back_x, want.back_y, want.back_z,
                     want.sh_x, want.sh_y, want.sh_z);
            $display("  got side %0d %0d %0d up %0d %0d %0d",
                     got.side_x, got.side_y, got.side_z,
                     got.up_x, got.up_y, got.up_z);
            $display("  got back %0d %0d %0d sh %0d %0d %0d",
                     got.back_x, got.back_y, got.back_z,
                     got.sh_x, got.sh_y, got.sh_z);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatches == 0 && expected_matrices.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
